### design/psc_pkg.sv
// ---------------------------------------------------------------------------
// psc_pkg
// Shared types and constants of the pressure sensor compensation block:
// field widths, calibration coefficient set and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

	// port field widths
	localparam int RAW_W   = 24;
	localparam int COEF_W  = 16;
	localparam int PRES_W  = 22;
	localparam int TEMP_W  = 19;
	localparam int CFG_A_W = 3;

	// internal arithmetic widths
	localparam int DT_W     = RAW_W + 1;         // signed difference D2 - C5*256
	localparam int PROD_W   = DT_W + COEF_W;     // dT times a coefficient
	localparam int OFF_W    = 35;                // offset term
	localparam int SENS_W   = 34;                // sensitivity term
	localparam int PROD_P_W = RAW_W + 1 + SENS_W; // D1 times sensitivity

	// temperature base in 0.01 degC
	localparam logic signed [TEMP_W:0] TEMP_BASE = (TEMP_W + 1)'(2000);

	// calibration coefficient register indexes
	typedef enum logic [CFG_A_W-1:0] {
		REG_SENS_BASE      = 3'd0,
		REG_OFFSET_BASE    = 3'd1,
		REG_SENS_TEMPCO    = 3'd2,
		REG_OFFSET_TEMPCO  = 3'd3,
		REG_REF_TEMP       = 3'd4,
		REG_TEMP_SLOPE     = 3'd5
	} cfg_reg_t;

	// calibration coefficient set
	typedef struct packed {
		logic [COEF_W-1:0] sens_base;     // C1
		logic [COEF_W-1:0] offset_base;   // C2
		logic [COEF_W-1:0] sens_tempco;   // C3
		logic [COEF_W-1:0] offset_tempco; // C4
		logic [COEF_W-1:0] ref_temp;      // C5
		logic [COEF_W-1:0] temp_slope;    // C6
	} coef_t;

endpackage

`default_nettype wire

### design/psc_coef_regs.sv
// ---------------------------------------------------------------------------
// psc_coef_regs
// Calibration coefficient register file, written through a valid/ready
// channel; writes to unknown indexes are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module psc_coef_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [psc_pkg::CFG_A_W-1:0]  cfg_index,
	input  wire logic [psc_pkg::COEF_W-1:0]   cfg_data,
	output psc_pkg::coef_t                    coef
);
	import psc_pkg::*;

	coef_t coef_q;

	// the register file takes a transfer in every cycle
	assign cfg_ready = 1'b1;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_SENS_BASE:     coef_q.sens_base     <= cfg_data;
				REG_OFFSET_BASE:   coef_q.offset_base   <= cfg_data;
				REG_SENS_TEMPCO:   coef_q.sens_tempco   <= cfg_data;
				REG_OFFSET_TEMPCO: coef_q.offset_tempco <= cfg_data;
				REG_REF_TEMP:      coef_q.ref_temp      <= cfg_data;
				REG_TEMP_SLOPE:    coef_q.temp_slope    <= cfg_data;
				default:           coef_q <= coef_q;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

`default_nettype wire

### design/psc_pipe.sv
// ---------------------------------------------------------------------------
// psc_pipe
// Five-stage compensation datapath: temperature difference, coefficient
// products, offset/sensitivity sums, pressure product, final scaling.
// ---------------------------------------------------------------------------
`default_nettype none

module psc_pipe (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire logic [psc_pkg::RAW_W-1:0]           d1,
	input  wire logic [psc_pkg::RAW_W-1:0]           d2,
	input  wire psc_pkg::coef_t                      coef,
	output logic                                     out_valid,
	output logic signed [psc_pkg::PRES_W-1:0]        pres,
	output logic signed [psc_pkg::TEMP_W-1:0]        temp
);
	import psc_pkg::*;

	// valid bits
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	// stage registers
	logic        [RAW_W-1:0]    d1_s1, d1_s2, d1_s3;
	logic signed [DT_W-1:0]     dt_s1;
	logic signed [PROD_W-1:0]   prod_off_s2, prod_sens_s2, prod_temp_s2;
	logic signed [OFF_W-1:0]    off_s3, off_s4;
	logic signed [SENS_W-1:0]   sens_s3;
	logic signed [TEMP_W-1:0]   temp_s3, temp_s4, temp_s5;
	logic signed [PROD_P_W-1:0] prod_p_s4;
	logic signed [PRES_W-1:0]   pres_s5;

	// combinational terms
	logic signed [DT_W-1:0]     dt_d;
	logic signed [OFF_W-1:0]    off_d;
	logic signed [SENS_W-1:0]   sens_d;
	logic signed [TEMP_W:0]     temp_wide;
	logic signed [TEMP_W-1:0]   temp_d;
	logic signed [PROD_P_W-23:0] p_scaled;
	logic signed [37:0]         p_diff;
	logic signed [PRES_W:0]     p_wide;
	logic signed [PRES_W-1:0]   pres_d;

	// stage 1: dT = D2 - C5*256
	assign dt_d = $signed({1'b0, d2}) - $signed({1'b0, coef.ref_temp, 8'h00});

	// stage 3: offset and sensitivity sums (floor shifts are bit selects)
	assign off_d  = $signed({3'b000, coef.offset_base, 16'h0000})
		+ $signed({prod_off_s2[PROD_W-1], prod_off_s2[PROD_W-1:7]});
	assign sens_d = $signed({3'b000, coef.sens_base, 15'h0000})
		+ $signed({prod_sens_s2[PROD_W-1], prod_sens_s2[PROD_W-1:8]});

	// stage 3: temperature = 2000 + dT*C6/2^23, saturated
	assign temp_wide = $signed({{2{prod_temp_s2[PROD_W-1]}}, prod_temp_s2[PROD_W-1:23]})
		+ TEMP_BASE;
	always_comb begin
		if (temp_wide[TEMP_W] != temp_wide[TEMP_W-1]) begin
			temp_d = temp_wide[TEMP_W] ? {1'b1, {(TEMP_W-1){1'b0}}}
				: {1'b0, {(TEMP_W-1){1'b1}}};
		end else begin
			temp_d = temp_wide[TEMP_W-1:0];
		end
	end

	// stage 5: (D1*SENS/2^21 - OFF)/2^15, saturated
	// the product stays below 2^57 in magnitude, so its top bit is a plain sign copy
	assign p_scaled = prod_p_s4[PROD_P_W-2:21];
	assign p_diff   = $signed({p_scaled[36], p_scaled})
		- $signed({{3{off_s4[OFF_W-1]}}, off_s4});
	assign p_wide   = p_diff[37:15];
	always_comb begin
		if (p_wide[PRES_W] != p_wide[PRES_W-1]) begin
			pres_d = p_wide[PRES_W] ? {1'b1, {(PRES_W-1){1'b0}}}
				: {1'b0, {(PRES_W-1){1'b1}}};
		end else begin
			pres_d = p_wide[PRES_W-1:0];
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// payload stages, one product per multiplier before each register
	always_ff @(posedge clk) begin
		// stage 1
		d1_s1 <= d1;
		dt_s1 <= dt_d;
		// stage 2
		d1_s2        <= d1_s1;
		prod_off_s2  <= dt_s1 * $signed({1'b0, coef.offset_tempco});
		prod_sens_s2 <= dt_s1 * $signed({1'b0, coef.sens_tempco});
		prod_temp_s2 <= dt_s1 * $signed({1'b0, coef.temp_slope});
		// stage 3
		d1_s3   <= d1_s2;
		off_s3  <= off_d;
		sens_s3 <= sens_d;
		temp_s3 <= temp_d;
		// stage 4
		prod_p_s4 <= $signed({1'b0, d1_s3}) * sens_s3;
		off_s4    <= off_s3;
		temp_s4   <= temp_s3;
		// stage 5
		pres_s5 <= pres_d;
		temp_s5 <= temp_s4;
	end

	assign out_valid = valid_s5;
	assign pres      = pres_s5;
	assign temp      = temp_s5;

endmodule

`default_nettype wire

### design/pressure_sensor_compensation.sv
// ---------------------------------------------------------------------------
// pressure_sensor_compensation
// First-order compensation of raw 24-bit pressure and temperature readings
// with six calibration coefficients.
//
// channel   handshake                 payload
// input     start, busy               raw_pressure, raw_temperature
// config    cfg_valid, cfg_ready      cfg_index, cfg_data
// result    result_valid (strobe)     pressure_out, temperature_out
//
// A pair is taken in every cycle; busy stays low. Each result comes out
// of the five-stage datapath, with the D1*SENS multiplier in the fourth
// stage. Results are strobed for one cycle and the receiver cannot
// stall them. Reset clears the valid bits and the coefficients to zero.
// ---------------------------------------------------------------------------
`default_nettype none

module pressure_sensor_compensation (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [psc_pkg::RAW_W-1:0]            raw_pressure,
	input  wire logic [psc_pkg::RAW_W-1:0]            raw_temperature,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [psc_pkg::CFG_A_W-1:0]          cfg_index,
	input  wire logic [psc_pkg::COEF_W-1:0]           cfg_data,
	output logic                                      result_valid,
	output logic signed [psc_pkg::PRES_W-1:0]         pressure_out,
	output logic signed [psc_pkg::TEMP_W-1:0]         temperature_out
);
	import psc_pkg::*;

	coef_t coef;
	logic  accept;

	// fully pipelined: a transfer is taken every cycle
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// calibration registers
	psc_coef_regs u_coef_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	// compensation datapath
	psc_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.d1        (raw_pressure),
		.d2        (raw_temperature),
		.coef      (coef),
		.out_valid (result_valid),
		.pres      (pressure_out),
		.temp      (temperature_out)
	);

endmodule

`default_nettype wire
